// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; only the edge detector core includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while rst is high.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

// ===== rtl/lted_pkg.sv =====
// Package for the luma threshold edge detector: sizes, register indexes,
// luma weights and shared types. No dependencies.
package lted_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW_W      = COL_W + 1;        // effective width, holds MAX_WIDTH
  localparam int LUMA_W    = 22;
  localparam int CHAN_W    = 8;
  localparam int IWIDTH_W  = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  // Rec.709 weights scaled by 10000; threshold is max_color * 1000.
  localparam logic [13:0] W_RED      = 14'd2126;
  localparam logic [13:0] W_GREEN    = 14'd7152;
  localparam logic [13:0] W_BLUE     = 14'd722;
  localparam logic [9:0]  THR_SCALE  = 10'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd2;

  localparam logic [CHAN_W-1:0]   MAX_COLOR_RST   = 8'd255;
  localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RST = 11'd1024;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_row;
  } raster_pos_t;

  // Image width clamped to 1 .. MAX_WIDTH.
  function automatic logic [EW_W-1:0] sat_width(input logic [IWIDTH_W-1:0] w);
    logic [EW_W-1:0] r;
    if (w == '0) begin
      r = EW_W'(1);
    end else if (int'(w) > MAX_WIDTH) begin
      r = EW_W'(MAX_WIDTH);
    end else begin
      r = EW_W'(w);
    end
    return r;
  endfunction

endpackage

// ===== rtl/luma_threshold_edge_detector_core.sv =====
// Luma threshold edge detector, top level.
// Depends on lted_pkg, lted_raster, lted_eval, lted_ram, assert_macros.svh.
//
// Takes RGB pixels in raster order, one item per clock, and returns one edge
// level per pixel: max_color where the Rec.709 luma (2126 R + 7152 G + 722 B,
// exact in fixed point) differs from its reference by at least a tenth of
// max_color, else 0. The reference is the left neighbour (edge_mode 0) or the
// pixel above (edge_mode 1), the latter held in a MAX_WIDTH x 22 line store.
// Column 0 in mode 0 and the first row in mode 1 always give 0. frame_start
// on s_tuser restarts at column 0 of row 0. Throughput is one item per clock
// while m_tready keeps the result register free; each pixel passes the input
// register (with the line store read), then the result register, which drives
// m_tvalid. The line store does one read and one write per clock; a read of
// the column written in the same clock (image width 1) is forwarded. No
// clearing pass after reset: line store entries are only used after the first
// row of a frame wrote them. image_width is clamped to 1 .. MAX_WIDTH.
// Configuration may be written only while no item is in flight.
`include "assert_macros.svh"

module luma_threshold_edge_detector_core (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [lted_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lted_pkg::CFG_DAT_W-1:0] cfg_data,
  // pixel input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic [0:0]                     s_tuser,   // frame_start
  // edge output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata    // edge_level
);
  import lted_pkg::*;

  // configuration registers
  logic              edge_mode;
  logic [CHAN_W-1:0] max_color;
  logic [LUMA_W-1:0] threshold;    // max_color * 1000
  logic [EW_W-1:0]   eff_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_mode <= 1'b0;
      max_color <= MAX_COLOR_RST;
      threshold <= LUMA_W'(THR_SCALE * MAX_COLOR_RST);
      eff_width <= sat_width(IMAGE_WIDTH_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_MODE: edge_mode <= cfg_data[0];
        CFG_MAX_COLOR: begin
          max_color <= cfg_data[CHAN_W-1:0];
          threshold <= LUMA_W'(THR_SCALE * cfg_data[CHAN_W-1:0]);
        end
        CFG_IMAGE_WIDTH: eff_width <= sat_width(cfg_data[IWIDTH_W-1:0]);
        default: ;
      endcase
    end
  end

  // handshakes: stage 1 moves on whenever the result register is free
  logic s_acc;
  logic s1_valid;
  logic s1_adv;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign s_acc    = s_tvalid && s_tready;

  // raster position of the item on the input side
  raster_pos_t pos;

  lted_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .advance     (s_acc),
    .frame_start (s_tuser[0]),
    .eff_width   (eff_width),
    .pos         (pos)
  );

  // stage 1 registers
  logic [CHAN_W-1:0] s1_red;
  logic [CHAN_W-1:0] s1_green;
  logic [CHAN_W-1:0] s1_blue;
  logic [COL_W-1:0]  s1_col;
  logic              s1_compare;
  logic              fwd_hit;      // line store read hit the column written that clock
  logic [LUMA_W-1:0] fwd_luma;
  logic [LUMA_W-1:0] left_luma;
  logic [LUMA_W-1:0] s1_luma;
  logic [LUMA_W-1:0] above_luma;
  logic [LUMA_W-1:0] ref_luma;
  logic [CHAN_W-1:0] s1_level;
  logic              ram_we;

  assign ram_we = s1_valid && s1_adv;

  lted_ram #(
    .WIDTH (LUMA_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col),
    .wdata (s1_luma),
    .re    (s_acc),
    .raddr (pos.col),
    .rdata (above_luma)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_red     <= s_tdata[7:0];
      s1_green   <= s_tdata[15:8];
      s1_blue    <= s_tdata[23:16];
      s1_col     <= pos.col;
      s1_compare <= edge_mode ? !pos.first_row : (pos.col != '0);
      fwd_hit    <= s1_valid && (s1_col == pos.col);
      fwd_luma   <= s1_luma;
    end
  end

  assign ref_luma = edge_mode ? (fwd_hit ? fwd_luma : above_luma) : left_luma;

  lted_eval u_eval (
    .red       (s1_red),
    .green     (s1_green),
    .blue      (s1_blue),
    .ref_luma  (ref_luma),
    .compare   (s1_compare),
    .threshold (threshold),
    .max_color (max_color),
    .luma      (s1_luma),
    .level     (s1_level)
  );

  // left neighbour luma, updated as each item leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      left_luma <= '0;
    end else if (ram_we) begin
      left_luma <= s1_luma;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ram_we) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      m_tdata <= s1_level;
    end
  end

  // checks
  `ASSERT_CLK(a_no_block_when_free, clk, rst, (!m_tvalid |-> s_tready),
              "input stalled while result register free")
  `ASSERT_CLK(a_level_values, clk, rst,
              (m_tvalid |-> (m_tdata == '0 || m_tdata == max_color)),
              "edge level neither zero nor max_color")
  `ASSERT_CLK(a_frame_start_col0, clk, rst, (s_acc && s_tuser[0] |=> s1_col == '0),
              "frame start item not placed at column zero")
  `ASSERT_CLK(a_col_in_width, clk, rst, (s1_valid |-> ({1'b0, s1_col} < eff_width)),
              "stage 1 column beyond image width")

endmodule

// ===== rtl/lted_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lted_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lted_raster.sv =====
// Raster position tracker: column counter and first-row flag.
// Depends on lted_pkg.
module lted_raster (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      frame_start,
  input  logic [lted_pkg::EW_W-1:0] eff_width,
  output lted_pkg::raster_pos_t     pos
);
  import lted_pkg::*;

  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic             first_row;
  logic             first_row_next;
  logic [COL_W-1:0] col_base;
  logic             row_base;
  logic [EW_W-1:0]  col_inc;

  always_comb begin
    col_base = frame_start ? '0 : column_count;
    row_base = frame_start | first_row;
    // width lowered mid-row restarts at column 0
    pos.col       = ({1'b0, col_base} >= eff_width) ? '0 : col_base;
    pos.first_row = row_base;
    col_inc       = {1'b0, pos.col} + EW_W'(1);
    if (col_inc >= eff_width) begin
      column_count_next = '0;
      first_row_next    = 1'b0;
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      first_row_next    = row_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (advance) begin
      column_count <= column_count_next;
      first_row    <= first_row_next;
    end
  end

endmodule

// ===== rtl/lted_eval.sv =====
// Luma and threshold compare for one pixel.
// Depends on lted_pkg.
module lted_eval (
  input  logic [lted_pkg::CHAN_W-1:0] red,
  input  logic [lted_pkg::CHAN_W-1:0] green,
  input  logic [lted_pkg::CHAN_W-1:0] blue,
  input  logic [lted_pkg::LUMA_W-1:0] ref_luma,
  input  logic                        compare,
  input  logic [lted_pkg::LUMA_W-1:0] threshold,
  input  logic [lted_pkg::CHAN_W-1:0] max_color,
  output logic [lted_pkg::LUMA_W-1:0] luma,
  output logic [lted_pkg::CHAN_W-1:0] level
);
  import lted_pkg::*;

  logic [LUMA_W-1:0] diff;

  always_comb begin
    luma = LUMA_W'(W_RED * red) + LUMA_W'(W_GREEN * green) + LUMA_W'(W_BLUE * blue);
    diff = (luma >= ref_luma) ? (luma - ref_luma) : (ref_luma - luma);
    level = (compare && (diff >= threshold)) ? max_color : '0;
  end

endmodule

// ===== dv/edge_level_checker.sv =====
`timescale 1ns / 100ps
// Edge level checker for luma_threshold_edge_detector_core: follows register
// writes, predicts one edge level per accepted pixel and compares in order.
// Depends on lted_pkg for port widths, register indexes and reset values.
module edge_level_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lted_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lted_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic [0:0]                     s_tuser,   // frame_start
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,   // edge_level
  output int                             mismatches,
  output int                             levels_outstanding
);

  // Rec.709 weights over 10000; an edge is a step of a tenth of max_color.
  localparam int LUMA_R = 2126;
  localparam int LUMA_G = 7152;
  localparam int LUMA_B = 722;
  localparam int TENTH  = 1000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  bit   [21:0] luma_above [lted_pkg::MAX_WIDTH];
  logic [21:0] luma_left;
  logic [10:0] next_col;
  logic        in_top_row;
  logic        cmp_above;
  logic [7:0]  edge_max;
  logic [10:0] row_len;
  logic [7:0]  levels_due [$];

  function automatic logic [7:0] predict_edge_level(rgb_t px, logic frame_start);
    int         span;
    int         col;
    int         luma;
    int         ref_luma;
    int         diff;
    logic       compared;
    logic [7:0] level;
    span = int'(row_len);
    if (span < 1) span = 1;
    if (span > lted_pkg::MAX_WIDTH) span = lted_pkg::MAX_WIDTH;
    if (frame_start) begin
      next_col   = '0;
      in_top_row = 1'b1;
    end
    col = int'(next_col);
    if (col >= span) col = 0;  // width was lowered mid-row
    luma = LUMA_R * int'(px.red) + LUMA_G * int'(px.green) + LUMA_B * int'(px.blue);
    if (cmp_above) begin
      compared = !in_top_row;
      ref_luma = int'(luma_above[col]);
    end else begin
      compared = (col != 0);
      ref_luma = int'(luma_left);
    end
    level = '0;
    if (compared) begin
      diff = (luma >= ref_luma) ? luma - ref_luma : ref_luma - luma;
      if (diff >= TENTH * int'(edge_max)) level = edge_max;
    end
    // both references follow every pixel, whatever the mode
    luma_above[col] = 22'(luma);
    luma_left       = 22'(luma);
    if (col + 1 >= span) begin
      next_col   = '0;
      in_top_row = 1'b0;
    end else begin
      next_col = 11'(col + 1);
    end
    return level;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      luma_left  = '0;
      next_col   = '0;
      in_top_row = 1'b1;
      cmp_above  = 1'b0;
      edge_max   = lted_pkg::MAX_COLOR_RST;
      row_len    = lted_pkg::IMAGE_WIDTH_RST;
      levels_due.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lted_pkg::CFG_EDGE_MODE:   cmp_above = cfg_data[0];
          lted_pkg::CFG_MAX_COLOR:   edge_max  = cfg_data[7:0];
          lted_pkg::CFG_IMAGE_WIDTH: row_len   = cfg_data[10:0];
          default: ;
        endcase
      end
      // results first, so a stray one cannot pair with a pixel taken this cycle
      if (m_tvalid && m_tready) begin
        if (levels_due.size() == 0) begin
          $display("%0t ns: edge level with nothing pending, expected none, got %0d",
                   $time, m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = levels_due.pop_front();
          if (m_tdata !== want) begin
            $display("%0t ns: edge level mismatch, expected %0d, got %0d",
                     $time, want, m_tdata);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_tvalid && s_tready)
        levels_due.push_back(predict_edge_level(rgb_t'(s_tdata), s_tuser[0]));
    end
    levels_outstanding <= levels_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the edge detector bench: clock, reset, pixel and register stimulus,
// output pacing and the verdict. Depends on lted_pkg, the core and edge_level_checker.
module testbench;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [lted_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lted_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata   = '0;   // red[7:0], green[15:8], blue[23:16]
  logic [0:0]                     s_tuser   = '0;   // frame_start
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [7:0]                     m_tdata;          // edge_level

  int mismatches;
  int levels_outstanding;

  // pacing and stimulus bookkeeping
  logic        steady     = 1'b0;   // phase with no gaps on either side
  logic        hold_req   = 1'b0;   // ask the receiver for its one long hold-off
  logic        hold_done  = 1'b0;
  logic        need_frame = 1'b0;   // width was raised: next phase opens a frame
  int          cur_span   = lted_pkg::MAX_WIDTH;
  logic [23:0] last_px    = '0;

  luma_threshold_edge_detector_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  edge_level_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .mismatches         (mismatches),
    .levels_outstanding (levels_outstanding)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pace_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pixels: fresh random, a small drift from the last one (so both edges and
  // flat areas show up), or channels pinned to the extremes.
  function automatic logic [23:0] next_pixel();
    logic [23:0] px;
    int          roll;
    int          k;
    int          v;
    roll = $urandom_range(0, 99);
    for (k = 0; k < 3; k++) begin
      if (roll < 40) begin
        v = $urandom_range(0, 255);
      end else if (roll < 85) begin
        v = int'(last_px[8*k +: 8]) + int'($urandom_range(0, 24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end else begin
        v = $urandom_range(0, 1) ? 255 : 0;
      end
      px[8*k +: 8] = 8'(v);
    end
    last_px = px;
    return px;
  endfunction

  // Offer one pixel, hold it until taken. tvalid gets one update per step:
  // lowered only when a gap actually follows.
  task automatic push_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic frame_start);
    int gap;
    gap = pace_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {blue, green, red};
    s_tuser  <= frame_start;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for the last edge level, plus a margin over the
  // two-stage pipeline before registers may change.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (levels_outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the idle cycle after it keeps cfg_we to one update per step.
  task automatic write_reg(input logic [lted_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lted_pkg::CFG_DAT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Program all three registers. Raising the row length without a new frame
  // would read line store columns never written, so that forces a frame start.
  task automatic configure(input logic mode, input logic [7:0] max_level,
                           input logic [10:0] width);
    int span;
    span = int'(width);
    if (span < 1) span = 1;
    if (span > lted_pkg::MAX_WIDTH) span = lted_pkg::MAX_WIDTH;
    need_frame = (span > cur_span);
    cur_span   = span;
    write_reg(lted_pkg::CFG_EDGE_MODE, lted_pkg::CFG_DAT_W'(mode));
    write_reg(lted_pkg::CFG_MAX_COLOR, lted_pkg::CFG_DAT_W'(max_level));
    write_reg(lted_pkg::CFG_IMAGE_WIDTH, width);
  endtask

  // Receiver: random back-pressure, plus one long hold-off while the sender
  // keeps offering, so the core fills up and drops s_tready.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = pace_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL luma_threshold_edge_detector_core");
    $finish;
  end

  initial begin
    int          sent;
    int          n_items;
    int          frame_len;
    int          k;
    int          roll;
    logic        mode;
    logic [7:0]  max_level;
    logic [10:0] width;
    logic        fresh;
    logic        frame_start;
    logic [23:0] px;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (left neighbor, max 255, width 1024): black/white swings,
    // each primary alone, a sub-threshold step, and a frame start that forces
    // column 0 to no edge even across a full swing.
    push_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    push_pixel(8'd1,   8'd1,   8'd1,   1'b0);
    push_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    push_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    push_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    drain();

    // max 10 puts the threshold at exactly one grey step (luma 10000):
    // hit exactly, just missed, row wrap back to column 0 at width 3.
    configure(1'b0, 8'd10, 11'd3);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd1, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd0, 1'b0);
    push_pixel(8'd2, 8'd2, 8'd2, 1'b0);
    drain();

    // Pixel above, width 0 clamps to 1: every pixel ends a row, and the line store
    // is read at the column the previous pixel writes, forwarded in the same clock.
    configure(1'b1, 8'd255, 11'd0);
    push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    push_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    push_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    drain();

    // Zero max_color with the widest width code (clamps to the maximum):
    // every compared pixel is an edge at level 0; channels exceed max_color.
    configure(1'b0, 8'd0, 11'd2047);
    push_pixel(8'd0,   8'd0, 8'd0, 1'b1);
    push_pixel(8'd7,   8'd7, 8'd7, 1'b0);
    push_pixel(8'd200, 8'd0, 8'd9, 1'b0);
    drain();

    // Random phases: mostly short rows over several lines so the pixel-above
    // path runs, a few very wide rows, odd frame starts as noise. Mode and
    // lowered widths carry over mid-row where no frame start is required.
    sent = 0;
    while (sent < 1300) begin
      mode = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      if (roll == 0)     max_level = 8'd0;
      else if (roll == 1) max_level = 8'd255;
      else if (roll < 4) max_level = 8'($urandom_range(1, 12));
      else               max_level = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 45)      width = 11'($urandom_range(1, 8));
      else if (roll < 75) width = 11'($urandom_range(9, 40));
      else if (roll < 88) width = 11'($urandom_range(41, 200));
      else begin
        case ($urandom_range(0, 4))
          0:       width = 11'd0;
          1:       width = 11'd1024;
          2:       width = 11'd2047;
          3:       width = 11'($urandom_range(1025, 2046));
          default: width = 11'($urandom_range(513, 1023));
        endcase
      end
      configure(mode, max_level, width);

      steady = ($urandom_range(0, 3) == 0);
      if (cur_span <= 64)
        n_items = cur_span * $urandom_range(2, 5) + $urandom_range(0, cur_span);
      else
        n_items = $urandom_range(24, 60);
      if (n_items < 24) n_items = 24;
      frame_len = cur_span * $urandom_range(2, 6);
      fresh = need_frame || ($urandom_range(0, 1) == 1);
      hold_req = 1'b1;  // takes effect once, during the first random phase

      for (k = 0; k < n_items; k++) begin
        frame_start = ((k % frame_len == 0) && (k > 0 || fresh)) ||
                      ($urandom_range(0, 49) == 0);
        px = next_pixel();
        push_pixel(px[7:0], px[15:8], px[23:16], frame_start);
      end
      drain();
      sent += n_items;
    end

    if (mismatches == 0 && levels_outstanding == 0) begin
      $display("PASS luma_threshold_edge_detector_core");
    end else begin
      $display("FAIL luma_threshold_edge_detector_core");
    end
    $finish;
  end

endmodule
